FILE: rtl/core/rgb_led_pulse_serializer_assert.svh
// Assertion macros for the LED pulse serializer checker
`ifndef RGB_LED_PULSE_SERIALIZER_ASSERT_SVH
`define RGB_LED_PULSE_SERIALIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RLPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RLPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rlps_pkg.sv
// Shared types and constants of the LED pulse serializer
package rlps_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_BRIGHTNESS  = 3'd0;
  localparam logic [2:0] REG_COLOR_ORDER = 3'd1;
  localparam logic [2:0] REG_ZERO_HIGH   = 3'd2;
  localparam logic [2:0] REG_ONE_HIGH    = 3'd3;
  localparam logic [2:0] REG_BIT_PERIOD  = 3'd4;
  localparam logic [2:0] REG_RESET_LEN   = 3'd5;

  // wire color orders
  localparam logic [1:0] ORDER_RGB = 2'd0;
  localparam logic [1:0] ORDER_GRB = 2'd1;
  localparam logic [1:0] ORDER_BRG = 2'd2;
  localparam logic [1:0] ORDER_BGR = 2'd3;

  // register reset values
  localparam logic [7:0]  RST_BRIGHTNESS  = 8'd255;
  localparam logic [1:0]  RST_COLOR_ORDER = ORDER_GRB;
  localparam logic [7:0]  RST_ZERO_HIGH   = 8'd17;
  localparam logic [7:0]  RST_ONE_HIGH    = 8'd45;
  localparam logic [7:0]  RST_BIT_PERIOD  = 8'd63;
  localparam logic [15:0] RST_RESET_LEN   = 16'd2500;

  // segment sequence: 48 bit segments, then the optional latch segment
  localparam logic [5:0] SEG_LAST_BIT_IDX = 6'd47;
  localparam logic [5:0] SEG_RESET_IDX    = 6'd48;

  // rounding offset of round(b*c/255) = floor((b*c + 127) / 255)
  localparam logic [15:0] ROUND_OFS = 16'd127;

  // segment timing handed to the serializer
  typedef struct packed {
    logic [7:0]  zero_high;
    logic [7:0]  one_high;
    logic [7:0]  bit_period;
    logic [15:0] reset_len;
  } rlps_timing_t;

endpackage

FILE: rtl/core/rlps_pixel_if.sv
// Pixel request channel: valid/ready plus one pixel
interface rlps_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

FILE: rtl/core/rlps_seg_if.sv
// Line segment request channel: valid/ready plus one segment
interface rlps_seg_if;
  logic        valid;
  logic        ready;
  logic        line_level;
  logic [15:0] duration;
  logic        last;

  modport source (output valid, line_level, duration, last, input ready);
  modport sink   (input valid, line_level, duration, last, output ready);
endinterface

FILE: rtl/core/rlps_lane.sv
// One color lane: brightness multiply, then divide-by-255 with rounding
module rlps_lane (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] chan,
  input  logic [7:0] bright,
  output logic [7:0] scaled
);
  import rlps_pkg::*;

  logic [15:0] prod_r;
  logic [15:0] y;
  logic [16:0] q_full;

  // stage 1: product
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= chan * bright;
    end
  end

  // floor(y/255) for y < 65535 as (y + (y>>8) + 1) >> 8
  assign y      = prod_r + ROUND_OFS;
  assign q_full = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
  assign scaled = q_full[15:8];
endmodule

FILE: rtl/core/rlps_merge.sv
// Merge stage: put the three lane results in wire order
module rlps_merge (
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [1:0]  color_order,
  output logic [23:0] word
);
  import rlps_pkg::*;

  logic [23:0] word_r;
  logic [23:0] word_nxt;

  // channel order on the wire, first byte in the top bits
  always_comb begin
    unique case (color_order)
      ORDER_RGB: word_nxt = {red, green, blue};
      ORDER_GRB: word_nxt = {green, red, blue};
      ORDER_BRG: word_nxt = {blue, red, green};
      ORDER_BGR: word_nxt = {blue, green, red};
      default:   word_nxt = {green, red, blue};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word = word_r;
endmodule

FILE: rtl/core/rlps_serializer.sv
// Serializer: turns a 24-bit word into high/low segments, one per cycle unless out_seg stalls
module rlps_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_valid,
  output logic                  load_ready,
  input  logic [23:0]           word,
  input  logic                  last_px,
  input  rlps_pkg::rlps_timing_t tm,
  rlps_seg_if.source            out_seg
);
  import rlps_pkg::*;

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [23:0] word_r;
  logic        lastpx_r;
  logic        ov_r;
  logic        lvl_r;
  logic [15:0] dur_r;
  logic        olast_r;

  logic        out_adv;
  logic        emit;
  logic        has_rst;
  logic        is_final;
  logic [7:0]  hi;
  logic [7:0]  lo;
  logic        seg_lvl;
  logic [15:0] seg_dur;

  assign out_adv    = !ov_r || out_seg.ready;
  assign emit       = busy_r && out_adv;
  assign has_rst    = lastpx_r && (tm.reset_len != 16'd0);
  assign is_final   = cnt_r == (has_rst ? SEG_RESET_IDX : SEG_LAST_BIT_IDX);
  assign load_ready = !busy_r || (emit && is_final);

  // segment of the current count: even = high part, odd = low part, index 48 = latch
  assign hi = word_r[23] ? tm.one_high : tm.zero_high;
  assign lo = (tm.bit_period > hi) ? (tm.bit_period - hi) : 8'd0;

  always_comb begin
    if (cnt_r == SEG_RESET_IDX) begin
      seg_lvl = 1'b0;
      seg_dur = tm.reset_len;
    end else if (!cnt_r[0]) begin
      seg_lvl = 1'b1;
      seg_dur = {8'd0, hi};
    end else begin
      seg_lvl = 1'b0;
      seg_dur = {8'd0, lo};
    end
  end

  // sequencing and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (emit) begin
        ov_r    <= 1'b1;
        lvl_r   <= seg_lvl;
        dur_r   <= seg_dur;
        olast_r <= is_final;
      end else if (out_adv) begin
        ov_r <= 1'b0;
      end
      // new word takes over once the last segment is out
      if (load_valid && load_ready) begin
        busy_r   <= 1'b1;
        cnt_r    <= 6'd0;
        word_r   <= word;
        lastpx_r <= last_px;
      end else begin
        if (emit) begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r[0]) begin
            word_r <= {word_r[22:0], 1'b0};
          end
        end
        if (emit && is_final) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign out_seg.valid      = ov_r;
  assign out_seg.line_level = lvl_r;
  assign out_seg.duration   = dur_r;
  assign out_seg.last       = olast_r;
endmodule

FILE: rtl/core/rgb_led_pulse_serializer.sv
// Top level of the LED pulse serializer
//
//   port      dir   handshake      content
//   in_px     in    valid/ready    red, green, blue, last_pixel
//   out_seg   out   valid/ready    line_level, duration, last
//   cfg_*     in    write enable   register index, write data
//
// Each pixel yields 48 segments, or 49 with the latch segment, one per cycle
// while out_seg is not stalled; the serializer's segment counter steps them.
// Pixel entry to first segment: multiply, merge, load and output registers.
// The next pixel waits, scaled, in the merge stage while one is serialized.
// A stalled output holds its segment; rst_n is synchronous and active low.
module rgb_led_pulse_serializer (
  input  logic        clk,
  input  logic        rst_n,
  rlps_pixel_if.sink  in_px,
  rlps_seg_if.source  out_seg,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import rlps_pkg::*;

  logic [7:0]  brightness_r;
  logic [1:0]  color_order_r;
  logic [7:0]  zero_high_r;
  logic [7:0]  one_high_r;
  logic [7:0]  bit_period_r;
  logic [15:0] reset_len_r;

  logic        v1_r;
  logic        v2_r;
  logic        last1_r;
  logic        last2_r;
  logic        adv1;
  logic        adv2;
  logic        in_fire;
  logic        ser_ready;
  logic [7:0]  red_s;
  logic [7:0]  green_s;
  logic [7:0]  blue_s;
  logic [23:0] word;
  rlps_timing_t tm;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r  <= RST_BRIGHTNESS;
      color_order_r <= RST_COLOR_ORDER;
      zero_high_r   <= RST_ZERO_HIGH;
      one_high_r    <= RST_ONE_HIGH;
      bit_period_r  <= RST_BIT_PERIOD;
      reset_len_r   <= RST_RESET_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRIGHTNESS:  brightness_r  <= cfg_wdata[7:0];
        REG_COLOR_ORDER: color_order_r <= cfg_wdata[1:0];
        REG_ZERO_HIGH:   zero_high_r   <= cfg_wdata[7:0];
        REG_ONE_HIGH:    one_high_r    <= cfg_wdata[7:0];
        REG_BIT_PERIOD:  bit_period_r  <= cfg_wdata[7:0];
        REG_RESET_LEN:   reset_len_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign tm = '{zero_high:  zero_high_r,
                one_high:   one_high_r,
                bit_period: bit_period_r,
                reset_len:  reset_len_r};

  // pipeline flow control
  assign adv2        = !v2_r || ser_ready;
  assign adv1        = !v1_r || adv2;
  assign in_px.ready = adv1;
  assign in_fire     = in_px.valid && adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_px.valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      last1_r <= in_px.last_pixel;
    end
    if (adv2 && v1_r) begin
      last2_r <= last1_r;
    end
  end

  // three lanes in parallel
  rlps_lane u_lane_r (
    .clk(clk), .en(in_fire), .chan(in_px.red), .bright(brightness_r), .scaled(red_s)
  );
  rlps_lane u_lane_g (
    .clk(clk), .en(in_fire), .chan(in_px.green), .bright(brightness_r), .scaled(green_s)
  );
  rlps_lane u_lane_b (
    .clk(clk), .en(in_fire), .chan(in_px.blue), .bright(brightness_r), .scaled(blue_s)
  );

  rlps_merge u_merge (
    .clk         (clk),
    .en          (adv2 && v1_r),
    .red         (red_s),
    .green       (green_s),
    .blue        (blue_s),
    .color_order (color_order_r),
    .word        (word)
  );

  rlps_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (v2_r),
    .load_ready (ser_ready),
    .word       (word),
    .last_px    (last2_r),
    .tm         (tm),
    .out_seg    (out_seg)
  );
endmodule

FILE: rtl/core/rlps_checker.sv
// Port-level checker for the LED pulse serializer, bound to the top level
`include "rgb_led_pulse_serializer_assert.svh"

module rlps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_level,
  input logic [15:0] out_duration,
  input logic        out_last
);

  // a stalled segment request keeps its contents
  `RLPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_level) && $stable(out_duration) && $stable(out_last), "stalled segment changed")

  // a pixel never ends on a high segment
  `RLPS_ASSERT_NOW(a_high_not_last, out_valid && out_level, !out_last, "high segment marked last")

  // a high segment is never directly followed by another high segment
  `RLPS_ASSERT_NEXT(a_high_then_low, out_valid && out_ready && out_level, !out_valid || !out_level, "two high segments in a row")

endmodule

bind rgb_led_pulse_serializer rlps_checker u_rlps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_seg.valid),
  .out_ready    (out_seg.ready),
  .out_level    (out_seg.line_level),
  .out_duration (out_seg.duration),
  .out_last     (out_seg.last)
);
